/* hw/rtl/sclk_pkg.sv */
// sclk_pkg: shared types, codes and helpers of the settable 24-hour clock
// holds the result record, mode and register codes and the segment decode
// no dependencies

package sclk_pkg;

   // configuration register indexes
   localparam logic CSR_TICKS_PER_SECOND = 1'b0;
   localparam logic CSR_SETTLE_READS     = 1'b1;

   // reset values of the configuration registers
   localparam logic [15:0] TICKS_PER_SECOND_RESET = 16'd1000;
   localparam logic [3:0]  SETTLE_READS_RESET     = 4'd5;

   // set mode codes
   localparam logic [1:0] MODE_RUN      = 2'd0;
   localparam logic [1:0] MODE_SET_SEC  = 2'd1;
   localparam logic [1:0] MODE_SET_MIN  = 2'd2;
   localparam logic [1:0] MODE_SET_HOUR = 2'd3;

   // limits of the time fields
   localparam logic [7:0] SEC_MAX  = 8'd59;
   localparam logic [7:0] MIN_MAX  = 8'd59;
   localparam logic [7:0] HOUR_MAX = 8'd23;
   localparam logic [3:0] STABLE_MAX = 4'd15;

   // active-low segment codes of digits 0..9, blank for anything else
   localparam logic [6:0] SEG_BLANK = 7'h7F;
   localparam logic [6:0] SEG_CODES [10] = '{
      7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h10
   };

   // one result record
   typedef struct packed {
      logic [6:0] hex_sec_units;
      logic [6:0] hex_sec_tens;
      logic [6:0] hex_min_units;
      logic [6:0] hex_min_tens;
      logic [6:0] hex_hour_units;
      logic [6:0] hex_hour_tens;
      logic [5:0] cur_seconds;
      logic [5:0] cur_minutes;
      logic [4:0] cur_hours;
   } rsp_type;

   // segment code of one decimal digit
   function automatic logic [6:0] seg_of(input logic [3:0] digit);
      logic [6:0] code;
      if (digit < 4'd10) begin
         code = SEG_CODES[digit];
      end else begin
         code = SEG_BLANK;
      end
      return code;
   endfunction

   // tens digit of a value below 64, by compare chain
   function automatic logic [3:0] tens_of(input logic [5:0] value);
      logic [3:0] tens;
      if (value >= 6'd60) begin
         tens = 4'd6;
      end else if (value >= 6'd50) begin
         tens = 4'd5;
      end else if (value >= 6'd40) begin
         tens = 4'd4;
      end else if (value >= 6'd30) begin
         tens = 4'd3;
      end else if (value >= 6'd20) begin
         tens = 4'd2;
      end else if (value >= 6'd10) begin
         tens = 4'd1;
      end else begin
         tens = 4'd0;
      end
      return tens;
   endfunction

   // units digit of a value below 64
   function automatic logic [3:0] units_of(input logic [5:0] value);
      logic [5:0] tens_x10;
      logic [5:0] rest;
      tens_x10 = 6'(tens_of(value)) * 6'd10;
      rest     = value - tens_x10;
      return rest[3:0];
   endfunction

endpackage

/* hw/rtl/settable_24h_clock_with_display_unit.sv */
// settable_24h_clock_with_display_unit: millisecond-tick 24-hour clock
// with switch setting, reset key and six seven-segment digit codes
// depends on sclk_pkg
// a result is registered into a two-entry result queue when its request is accepted
// throughput: one request per cycle while that queue is not full; the queue lets
// requests keep coming while one result waits under rsp_stall
// reset (synchronous, active high): time, counters and mode tracking cleared,
// key taken as released, registers back to 1000 ticks and 5 settle reads

module settable_24h_clock_with_display_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_set_digits,
   input  logic [1:0]  req_set_mode,
   input  logic        req_key_level,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_hex_sec_units,
   output logic [6:0]  rsp_hex_sec_tens,
   output logic [6:0]  rsp_hex_min_units,
   output logic [6:0]  rsp_hex_min_tens,
   output logic [6:0]  rsp_hex_hour_units,
   output logic [6:0]  rsp_hex_hour_tens,
   output logic [5:0]  rsp_cur_seconds,
   output logic [5:0]  rsp_cur_minutes,
   output logic [4:0]  rsp_cur_hours,
   // configuration port
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);

   // configuration registers
   logic [15:0] ticks_per_second_ff;
   logic [3:0]  settle_reads_ff;

   // clock state
   logic [5:0]  seconds_ff, seconds_in;
   logic [5:0]  minutes_ff, minutes_in;
   logic [4:0]  hours_ff, hours_in;
   logic [15:0] tick_count_ff, tick_count_in;
   logic [1:0]  last_mode_ff, last_mode_in;
   logic [3:0]  stable_count_ff, stable_count_in;
   logic [7:0]  applied_digits_ff, applied_digits_in;
   logic        applied_valid_ff, applied_valid_in;
   logic        last_key_ff, last_key_in;

   // result queue
   sclk_pkg::rsp_type slot_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff, count_in;

   logic              req_accept, rsp_accept;
   sclk_pkg::rsp_type result;
   sclk_pkg::rsp_type head;

   // handshake
   assign req_stall  = (count_ff == 2'd2);
   assign rsp_valid  = (count_ff != 2'd0);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_second_ff <= sclk_pkg::TICKS_PER_SECOND_RESET;
         settle_reads_ff     <= sclk_pkg::SETTLE_READS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            sclk_pkg::CSR_TICKS_PER_SECOND: ticks_per_second_ff <= csr_write_data;
            sclk_pkg::CSR_SETTLE_READS:     settle_reads_ff     <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   // per-tick update: key clear, switch setting, display sample, advance
   always_comb begin
      logic       key_clear;
      logic [5:0] sec_a, min_a;
      logic [4:0] hour_a;
      logic [3:0] stable_inc;
      logic       do_set;
      logic [7:0] set_val;
      logic [7:0] clamp_sec, clamp_min, clamp_hour;
      logic [5:0] sec_b, min_b;
      logic [4:0] hour_b;
      logic [15:0] tick_next;
      logic [6:0] sec_c, min_c;
      logic [5:0] hour_c;

      // falling edge of the active-low key clears the time
      key_clear = !req_key_level && last_key_ff;
      sec_a  = key_clear ? 6'd0 : seconds_ff;
      min_a  = key_clear ? 6'd0 : minutes_ff;
      hour_a = key_clear ? 5'd0 : hours_ff;
      last_key_in = req_key_level;

      // mode tracking and settle count
      stable_inc = (stable_count_ff < sclk_pkg::STABLE_MAX) ?
                   stable_count_ff + 4'd1 : stable_count_ff;
      do_set = 1'b0;
      last_mode_in      = last_mode_ff;
      stable_count_in   = stable_count_ff;
      applied_valid_in  = applied_valid_ff;
      applied_digits_in = applied_digits_ff;
      if (req_set_mode != last_mode_ff) begin
         last_mode_in     = req_set_mode;
         stable_count_in  = 4'd0;
         applied_valid_in = 1'b0;
      end else begin
         stable_count_in = stable_inc;
         do_set = (stable_inc >= settle_reads_ff) &&
                  (req_set_mode != sclk_pkg::MODE_RUN) &&
                  (!applied_valid_ff || (req_set_digits != applied_digits_ff));
      end

      // switch value, clamped per field
      set_val    = 8'(req_set_digits[7:4]) * 8'd10 + 8'(req_set_digits[3:0]);
      clamp_sec  = (set_val > sclk_pkg::SEC_MAX)  ? sclk_pkg::SEC_MAX  : set_val;
      clamp_min  = (set_val > sclk_pkg::MIN_MAX)  ? sclk_pkg::MIN_MAX  : set_val;
      clamp_hour = (set_val > sclk_pkg::HOUR_MAX) ? sclk_pkg::HOUR_MAX : set_val;
      sec_b  = sec_a;
      min_b  = min_a;
      hour_b = hour_a;
      if (do_set) begin
         applied_digits_in = req_set_digits;
         applied_valid_in  = 1'b1;
         case (req_set_mode)
            sclk_pkg::MODE_SET_SEC:  sec_b  = clamp_sec[5:0];
            sclk_pkg::MODE_SET_MIN:  min_b  = clamp_min[5:0];
            sclk_pkg::MODE_SET_HOUR: hour_b = clamp_hour[4:0];
            default: ;
         endcase
      end

      // display sample
      result.hex_sec_units  = sclk_pkg::seg_of(sclk_pkg::units_of(sec_b));
      result.hex_sec_tens   = sclk_pkg::seg_of(sclk_pkg::tens_of(sec_b));
      result.hex_min_units  = sclk_pkg::seg_of(sclk_pkg::units_of(min_b));
      result.hex_min_tens   = sclk_pkg::seg_of(sclk_pkg::tens_of(min_b));
      result.hex_hour_units = sclk_pkg::seg_of(sclk_pkg::units_of({1'b0, hour_b}));
      result.hex_hour_tens  = sclk_pkg::seg_of(sclk_pkg::tens_of({1'b0, hour_b}));
      result.cur_seconds    = sec_b;
      result.cur_minutes    = min_b;
      result.cur_hours      = hour_b;

      // one-second advance in run mode
      tick_next = tick_count_ff + 16'd1;
      sec_c  = {1'b0, sec_b};
      min_c  = {1'b0, min_b};
      hour_c = {1'b0, hour_b};
      tick_count_in = tick_next;
      if (tick_next >= ticks_per_second_ff) begin
         tick_count_in = 16'd0;
         if (req_set_mode == sclk_pkg::MODE_RUN) begin
            sec_c = sec_c + 7'd1;
            if (sec_c >= 7'd60) begin
               sec_c = 7'd0;
               min_c = min_c + 7'd1;
            end
            if (min_c >= 7'd60) begin
               min_c  = 7'd0;
               hour_c = hour_c + 6'd1;
            end
            if (hour_c >= 6'd24) begin
               hour_c = 6'd0;
            end
         end
      end
      seconds_in = sec_c[5:0];
      minutes_in = min_c[5:0];
      hours_in   = hour_c[4:0];
   end

   // state registers, updated per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         seconds_ff        <= 6'd0;
         minutes_ff        <= 6'd0;
         hours_ff          <= 5'd0;
         tick_count_ff     <= 16'd0;
         last_mode_ff      <= sclk_pkg::MODE_RUN;
         stable_count_ff   <= 4'd0;
         applied_digits_ff <= 8'd0;
         applied_valid_ff  <= 1'b0;
         last_key_ff       <= 1'b1;
      end else if (req_accept) begin
         seconds_ff        <= seconds_in;
         minutes_ff        <= minutes_in;
         hours_ff          <= hours_in;
         tick_count_ff     <= tick_count_in;
         last_mode_ff      <= last_mode_in;
         stable_count_ff   <= stable_count_in;
         applied_digits_ff <= applied_digits_in;
         applied_valid_ff  <= applied_valid_in;
         last_key_ff       <= last_key_in;
      end
   end

   // result queue pointers and fill count
   always_comb begin
      count_in = count_ff;
      case ({req_accept, rsp_accept})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (req_accept) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (rsp_accept) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   // result slots
   always_ff @(posedge clock) begin
      if (req_accept) begin
         slot_ff[wr_ptr_ff] <= result;
      end
   end

   // result ports from the queue head
   assign head               = slot_ff[rd_ptr_ff];
   assign rsp_hex_sec_units  = head.hex_sec_units;
   assign rsp_hex_sec_tens   = head.hex_sec_tens;
   assign rsp_hex_min_units  = head.hex_min_units;
   assign rsp_hex_min_tens   = head.hex_min_tens;
   assign rsp_hex_hour_units = head.hex_hour_units;
   assign rsp_hex_hour_tens  = head.hex_hour_tens;
   assign rsp_cur_seconds    = head.cur_seconds;
   assign rsp_cur_minutes    = head.cur_minutes;
   assign rsp_cur_hours      = head.cur_hours;

endmodule

/* hw/rtl/sclk_checker.sv */
// sclk_checker: port-level assertions for the settable 24-hour clock
// bound to settable_24h_clock_with_display_unit; no package dependency

module sclk_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_set_digits,
   input logic [1:0]  req_set_mode,
   input logic        req_key_level,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [6:0]  rsp_hex_sec_units,
   input logic [6:0]  rsp_hex_sec_tens,
   input logic [6:0]  rsp_hex_min_units,
   input logic [6:0]  rsp_hex_min_tens,
   input logic [6:0]  rsp_hex_hour_units,
   input logic [6:0]  rsp_hex_hour_tens,
   input logic [5:0]  rsp_cur_seconds,
   input logic [5:0]  rsp_cur_minutes,
   input logic [4:0]  rsp_cur_hours,
   input logic        csr_write_enable,
   input logic        csr_index,
   input logic [15:0] csr_write_data
);

   // no result is pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an accepted request always leaves a result pending next cycle
   a_request_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request left no result");

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
      rsp_valid && $stable(rsp_cur_seconds) && $stable(rsp_cur_minutes) &&
      $stable(rsp_cur_hours) && $stable(rsp_hex_sec_units))
      else $error("stalled result changed");

   // shown time stays within a day
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cur_seconds <= 6'd59 && rsp_cur_minutes <= 6'd59 &&
      rsp_cur_hours <= 5'd23)
      else $error("time out of range");

   // midnight shows zeros on all six digits
   a_midnight_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cur_seconds == 6'd0 && rsp_cur_minutes == 6'd0 &&
      rsp_cur_hours == 5'd0 |->
      rsp_hex_sec_units == 7'h40 && rsp_hex_sec_tens == 7'h40 &&
      rsp_hex_min_units == 7'h40 && rsp_hex_min_tens == 7'h40 &&
      rsp_hex_hour_units == 7'h40 && rsp_hex_hour_tens == 7'h40)
      else $error("digit codes do not match zero time");

endmodule

bind settable_24h_clock_with_display_unit sclk_checker u_sclk_checker (.*);
